// ===== src/rmsi_pkg.sv =====
// Shared codes and constants for the sound-board interface core.
package rmsi_pkg;

  // Command codes carried on in_tuser
  localparam logic [3:0] CMD_RIOT_RD  = 4'd0;
  localparam logic [3:0] CMD_RIOT_WR  = 4'd1;
  localparam logic [3:0] CMD_FIFO_POP = 4'd2;
  localparam logic [3:0] CMD_REPLY_WR = 4'd3;
  localparam logic [3:0] CMD_REPLY_RD = 4'd4;
  localparam logic [3:0] CMD_READY_RD = 4'd5;
  localparam logic [3:0] CMD_FIFO_PSH = 4'd6;
  localparam logic [3:0] CMD_SND_RST  = 4'd7;
  localparam logic [3:0] CMD_TICK     = 4'd8;

  // RIOT register offsets
  localparam logic [4:0] ADR_PORT_A   = 5'd0;
  localparam logic [4:0] ADR_DIR_A    = 5'd1;
  localparam logic [4:0] ADR_PORT_B   = 5'd2;
  localparam logic [4:0] ADR_DIR_B    = 5'd3;
  localparam logic [4:0] ADR_IRQ_FLG  = 5'd5;
  localparam logic [4:0] ADR_TMR_LOAD = 5'd31;

  // Bit masks
  localparam logic [7:0] PA_LOW7_MASK  = 8'h7f;
  localparam logic [7:0] PA_FORCED_B4  = 8'h10;
  localparam logic [7:0] PA_FIFO_NE    = 8'h80;
  localparam logic [7:0] PA_SPCH_NRDY  = 8'h04;
  localparam logic [7:0] PA_REPLY_FULL = 8'h40;
  localparam logic [7:0] PA_CLR_REPLY  = 8'hbf;
  localparam logic [7:0] PA_CLR_TOP2   = 8'h3f;
  localparam logic [7:0] IRQ_TIMER     = 8'h80;
  localparam logic [7:0] RDY_FIFO_FULL = 8'h80;

  localparam int FIFO_DEPTH_DEF = 8;

  // One result beat
  typedef struct packed {
    logic       fifo_overrun;
    logic       fifo_underrun;
    logic       irq_pulse;
    logic [7:0] speech_byte;
    logic       speech_strobe;
    logic [7:0] read_data;
  } rmsi_result_t;

endpackage

// ===== src/riot_mailbox_sound_interface_core.sv =====
// Sound-board interface core: 6532-style ports and timer, command FIFO, reply mailbox.
// A result beat is formed in order: the item capture and command-store read at accept,
// then the update of state and the result register.
// The core holds one beat at a time: in_tready stays low until the held beat has
// been through its update step, and a result left untaken holds the update step.
// Reset (rst_n low, synchronous) clears the state registers and the entry valid bits, so
// every command-store entry reads as zero until written; no clearing pass.
module riot_mailbox_sound_interface_core import rmsi_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [4:0] address, [12:5] data, [13] speech_ready, [15:14] zero
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,   // [3:0] command
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [7:0] read_data, [8] speech_strobe, [16:9] speech_byte,
  //            [17] irq_pulse, [18] fifo_underrun, [19] fifo_overrun, [23:20] zero
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Item held while it executes
  logic            busy_r;
  logic [3:0]      cmd_r;
  logic [4:0]      addr_r;
  logic [7:0]      data_r;
  logic            rdy_r;

  // Architectural registers
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       reply_r, reply_nxt;
  logic [7:0]       pa_r, pa_nxt;
  logic [7:0]       pb_r, pb_nxt;
  logic [7:0]       da_r, da_nxt;
  logic [7:0]       db_r, db_nxt;
  logic [7:0]       tmr_r, tmr_nxt;
  logic             tmr_on_r, tmr_on_nxt;
  logic [7:0]       irqf_r, irqf_nxt;

  // Command store
  logic [7:0]            mem [FIFO_DEPTH];
  logic [FIFO_DEPTH-1:0] vld_r;
  logic [7:0]            mem_q;
  logic                  mem_q_vld;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_wa;
  logic [7:0]            head_byte;

  // Result register
  logic         out_vld_r;
  rmsi_result_t res_r, res_nxt;

  logic in_go, exec_go;
  logic fifo_full;
  logic [7:0] tmr_dec;
  logic [7:0] pa_wr;

  assign in_tready = !busy_r;
  assign in_go     = in_tvalid && in_tready;
  assign exec_go   = busy_r && (!out_vld_r || out_tready);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, res_r};

  assign fifo_full = (cnt_r == CNT_FULL);
  assign head_byte = mem_q_vld ? mem_q : 8'h00;
  assign tmr_dec   = tmr_r - 8'd1;
  assign pa_wr     = (pa_r & ~da_r) | (data_r & da_r);

  // Synchronous memory: read at accept, write during execute
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= data_r;
    end
    if (in_go) begin
      mem_q <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      mem_q_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
      if (in_go) begin
        mem_q_vld <= vld_r[head_r];
      end
    end
  end

  // Update of state and result
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    reply_nxt  = reply_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    tmr_nxt    = tmr_r;
    tmr_on_nxt = tmr_on_r;
    irqf_nxt   = irqf_r;
    res_nxt    = '0;
    mem_we     = 1'b0;
    mem_wa     = tail_r;

    unique case (cmd_r)
      CMD_RIOT_RD: begin
        unique case (addr_r)
          ADR_PORT_A: res_nxt.read_data = (pa_r & PA_LOW7_MASK) | PA_FORCED_B4
                                         | ((cnt_r != '0) ? PA_FIFO_NE : 8'h00)
                                         | (rdy_r ? 8'h00 : PA_SPCH_NRDY);
          ADR_DIR_A:  res_nxt.read_data = da_r;
          ADR_PORT_B: res_nxt.read_data = pb_r;
          ADR_DIR_B:  res_nxt.read_data = db_r;
          ADR_IRQ_FLG: begin
            res_nxt.read_data = irqf_r;
            irqf_nxt          = 8'h00;
          end
          default: ;
        endcase
      end
      CMD_RIOT_WR: begin
        unique case (addr_r)
          ADR_PORT_A: begin
            pa_nxt = pa_wr;
            if (pa_r[0] && !pa_wr[0]) begin
              res_nxt.speech_strobe = 1'b1;
              res_nxt.speech_byte   = pb_r;
            end
          end
          ADR_DIR_A:  da_nxt = data_r;
          ADR_PORT_B: pb_nxt = data_r;
          ADR_DIR_B:  db_nxt = data_r;
          ADR_TMR_LOAD: begin
            tmr_nxt    = {1'b0, data_r[7:1]};
            tmr_on_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_FIFO_POP: begin
        res_nxt.read_data = head_byte;
        if (cnt_r == '0) begin
          res_nxt.fifo_underrun = 1'b1;
        end else begin
          cnt_nxt  = cnt_r - CNT_W'(1);
          head_nxt = ptr_inc(head_r);
        end
      end
      CMD_REPLY_WR: begin
        reply_nxt = data_r;
        pa_nxt    = pa_r | PA_REPLY_FULL;
      end
      CMD_REPLY_RD: begin
        pa_nxt            = pa_r & PA_CLR_REPLY;
        res_nxt.read_data = reply_r;
      end
      CMD_READY_RD: begin
        res_nxt.read_data = (pa_r & PA_REPLY_FULL) | (fifo_full ? RDY_FIFO_FULL : 8'h00);
      end
      CMD_FIFO_PSH: begin
        mem_we = 1'b1;
        if (fifo_full) begin
          // overrun: head entry replaced, FIFO collapses to one item
          res_nxt.fifo_overrun = 1'b1;
          mem_wa   = head_r;
          cnt_nxt  = CNT_W'(1);
          tail_nxt = ptr_inc(head_r);
        end else begin
          tail_nxt = ptr_inc(tail_r);
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      CMD_SND_RST: begin
        reply_nxt = 8'h00;
        head_nxt  = '0;
        tail_nxt  = '0;
        cnt_nxt   = '0;
        pa_nxt    = pa_r & PA_CLR_TOP2;
      end
      CMD_TICK: begin
        if (tmr_on_r) begin
          tmr_nxt = tmr_dec;
          if (tmr_dec == 8'h00) begin
            tmr_on_nxt        = 1'b0;
            irqf_nxt          = irqf_r | IRQ_TIMER;
            res_nxt.irq_pulse = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (!exec_go) begin
      mem_we = 1'b0;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_go) begin
      cmd_r  <= in_tuser;
      addr_r <= in_tdata[4:0];
      data_r <= in_tdata[12:5];
      rdy_r  <= in_tdata[13];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      reply_r   <= 8'h00;
      pa_r      <= 8'h00;
      pb_r      <= 8'h00;
      da_r      <= 8'h00;
      db_r      <= 8'h00;
      tmr_r     <= 8'h00;
      tmr_on_r  <= 1'b0;
      irqf_r    <= 8'h00;
    end else begin
      if (in_go) begin
        busy_r <= 1'b1;
      end else if (exec_go) begin
        busy_r <= 1'b0;
      end

      if (exec_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (exec_go) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        cnt_r    <= cnt_nxt;
        reply_r  <= reply_nxt;
        pa_r     <= pa_nxt;
        pb_r     <= pb_nxt;
        da_r     <= da_nxt;
        db_r     <= db_nxt;
        tmr_r    <= tmr_nxt;
        tmr_on_r <= tmr_on_nxt;
        irqf_r   <= irqf_nxt;
      end
    end
  end

endmodule

// ===== bench/riot_mailbox_sound_interface_core_tb.sv =====
// Self-checking bench for the sound-board interface core: directed and random bus beats.
module riot_mailbox_sound_interface_core_tb;
  import rmsi_pkg::*;

  localparam int DEPTH       = FIFO_DEPTH_DEF;
  localparam int SH_PTR_W    = $clog2(DEPTH);
  localparam int N_ITEMS     = 1100;
  localparam int IDLE_LIMIT  = 2000;  // cycles without any beat moving
  localparam int DRAIN_WAIT  = 8;     // settle time after the drain loop

  // One bus access or tick as the bench sees it
  typedef struct packed {
    logic [3:0] cmd;
    logic [4:0] addr;
    logic [7:0] data;
    logic       rdy;
  } snd_beat_t;

  // Receiver stall styles
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BLOCKED} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // in_tdata: [4:0] address, [12:5] data, [13] speech_ready, [15:14] zero
  logic [15:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;  // [3:0] command
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // out_tdata: [7:0] read_data, [8] speech_strobe, [16:9] speech_byte,
  //            [17] irq_pulse, [18] fifo_underrun, [19] fifo_overrun, [23:20] zero
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  riot_mailbox_sound_interface_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be sent, and results the core still owes us
  snd_beat_t    bus_access_q[$];
  rmsi_result_t pending_responses[$];
  int           n_real_items = 0;
  int           err_count = 0;
  int           idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the core state
  // ---------------------------------------------------------------------------
  logic [7:0]          snd_store [DEPTH];
  logic [SH_PTR_W-1:0] sh_rd_ptr, sh_wr_ptr;
  int                  fifo_fill;
  logic [7:0]          reply_latch, pa_latch, pb_latch, pa_dir, pb_dir;
  logic [7:0]          tmr_count, irq_latch;
  logic                tmr_running;

  function automatic logic [SH_PTR_W-1:0] shadow_next(input logic [SH_PTR_W-1:0] p);
    return (p == SH_PTR_W'(DEPTH - 1)) ? '0 : p + SH_PTR_W'(1);
  endfunction

  task automatic clear_shadow();
    foreach (snd_store[i]) snd_store[i] = '0;
    sh_rd_ptr   = '0;
    sh_wr_ptr   = '0;
    fifo_fill   = 0;
    reply_latch = '0;
    pa_latch    = '0;
    pb_latch    = '0;
    pa_dir      = '0;
    pb_dir      = '0;
    tmr_count   = '0;
    tmr_running = 1'b0;
    irq_latch   = '0;
  endtask

  // Apply one accepted beat to the shadow state and queue the result it owes.
  task automatic compute_sound_response(input snd_beat_t b);
    rmsi_result_t r;
    logic         pa0_was_high;
    r = '0;
    case (b.cmd)
      CMD_RIOT_RD: begin
        case (b.addr)
          ADR_PORT_A: begin
            // bit 7 = fifo not empty, bit 4 stuck high, bit 2 = speech busy
            r.read_data = (pa_latch & PA_LOW7_MASK) | PA_FORCED_B4
                        | ((fifo_fill != 0) ? PA_FIFO_NE : 8'h00)
                        | (b.rdy ? 8'h00 : PA_SPCH_NRDY);
          end
          ADR_DIR_A:   r.read_data = pa_dir;
          ADR_PORT_B:  r.read_data = pb_latch;
          ADR_DIR_B:   r.read_data = pb_dir;
          ADR_IRQ_FLG: begin
            // read clears
            r.read_data = irq_latch;
            irq_latch   = '0;
          end
          default: ;
        endcase
      end
      CMD_RIOT_WR: begin
        case (b.addr)
          ADR_PORT_A: begin
            pa0_was_high = pa_latch[0];
            pa_latch = (pa_latch & ~pa_dir) | (b.data & pa_dir);
            // falling bit 0 strobes port B to the speech chip
            if (pa0_was_high && !pa_latch[0]) begin
              r.speech_strobe = 1'b1;
              r.speech_byte   = pb_latch;
            end
          end
          ADR_DIR_A:    pa_dir   = b.data;
          ADR_PORT_B:   pb_latch = b.data;  // dir B has no effect
          ADR_DIR_B:    pb_dir   = b.data;
          ADR_TMR_LOAD: begin
            tmr_count   = b.data >> 1;
            tmr_running = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_FIFO_POP: begin
        r.read_data = snd_store[sh_rd_ptr];
        if (fifo_fill == 0) begin
          r.fifo_underrun = 1'b1;  // head entry shown, nothing moves
        end else begin
          fifo_fill--;
          sh_rd_ptr = shadow_next(sh_rd_ptr);
        end
      end
      CMD_REPLY_WR: begin
        reply_latch = b.data;
        pa_latch    = pa_latch | PA_REPLY_FULL;
      end
      CMD_REPLY_RD: begin
        pa_latch    = pa_latch & PA_CLR_REPLY;
        r.read_data = reply_latch;
      end
      CMD_READY_RD: begin
        r.read_data = (pa_latch & PA_REPLY_FULL)
                    | ((fifo_fill >= DEPTH) ? RDY_FIFO_FULL : 8'h00);
      end
      CMD_FIFO_PSH: begin
        if (fifo_fill >= DEPTH) begin
          // full: head entry overwritten, fifo collapses to that one entry
          r.fifo_overrun       = 1'b1;
          fifo_fill            = 1;
          snd_store[sh_rd_ptr] = b.data;
          sh_wr_ptr            = shadow_next(sh_rd_ptr);
        end else begin
          snd_store[sh_wr_ptr] = b.data;
          sh_wr_ptr            = shadow_next(sh_wr_ptr);
          fifo_fill++;
        end
      end
      CMD_SND_RST: begin
        reply_latch = '0;
        sh_rd_ptr   = '0;
        sh_wr_ptr   = '0;
        fifo_fill   = 0;
        pa_latch    = pa_latch & PA_CLR_TOP2;
      end
      CMD_TICK: begin
        if (tmr_running) begin
          tmr_count = tmr_count - 8'd1;  // a zero load wraps to 255
          if (tmr_count == 8'd0) begin
            tmr_running = 1'b0;
            irq_latch   = irq_latch | IRQ_TIMER;
            r.irq_pulse = 1'b1;
          end
        end
      end
      default: ;  // unused commands: all zero
    endcase
    pending_responses.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_beat(input logic [3:0] cmd, input logic [4:0] addr,
                          input logic [7:0] data, input logic rdy);
    snd_beat_t b;
    b.cmd  = cmd;
    b.addr = addr;
    b.data = data;
    b.rdy  = rdy;
    bus_access_q.push_back(b);
    if (cmd <= CMD_TICK) n_real_items++;
  endtask

  function automatic logic [7:0] rand_byte();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [4:0] rand_addr();
    int unsigned p;
    p = $urandom_range(0, 9);
    case (p)
      0, 1: return ADR_PORT_A;
      2:    return ADR_DIR_A;
      3:    return ADR_PORT_B;
      4:    return ADR_DIR_B;
      5:    return ADR_IRQ_FLG;
      6:    return ADR_TMR_LOAD;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic logic rand_rdy();
    return 1'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drv
    snd_beat_t nb;
    logic      nv;
    nv = 1'b0;
    nb = '0;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (burst_left == 0) begin
        // roughly a third of the bursts follow the last with no gap at all
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                     ($urandom_range(0, 9) == 0) ? $urandom_range(13, 25)
                                                 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (bus_access_q.size() > 0) begin
        nb = bus_access_q.pop_front();
        nv = 1'b1;
        burst_left--;
      end
      in_tvalid <= nv;
      if (nv) begin
        in_tdata <= {2'b00, nb.rdy, nb.data, nb.addr};
        in_tuser <= nb.cmd;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_tready follows a changing stall pattern
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_period = 1;
  int       rx_phase = 0;

  always @(posedge clk) begin : rx_pattern
    logic rdy;
    if (rx_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      rx_period = $urandom_range(2, 8);
      rx_phase  = 0;
      rx_left   = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 40) : $urandom_range(10, 150);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:     rdy = 1'b1;
      RX_COIN:     rdy = 1'($urandom_range(0, 1));
      RX_PERIODIC: begin
        rdy      = (rx_phase == 0);
        rx_phase = (rx_phase + 1) % rx_period;
      end
      default:     rdy = 1'b0;
    endcase
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input beat, check every output beat, watchdog
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t ERROR %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : mon
    snd_beat_t    b;
    rmsi_result_t act, expd;
    logic         moved;
    if (rst_n) begin
      moved = 1'b0;
      // predict first so a same-edge result would still find its expectation
      if (in_tvalid && in_tready) begin
        b.addr = in_tdata[4:0];
        b.data = in_tdata[12:5];
        b.rdy  = in_tdata[13];
        b.cmd  = in_tuser;
        compute_sound_response(b);
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        act   = rmsi_result_t'(out_tdata[19:0]);
        if (pending_responses.size() == 0) begin
          err_count++;
          $display("%0t ERROR unexpected result beat: expected none, actual %h",
                   $time, out_tdata);
        end else begin
          expd = pending_responses.pop_front();
          report_field("read_data", expd.read_data, act.read_data);
          report_field("speech_strobe", 8'(expd.speech_strobe), 8'(act.speech_strobe));
          report_field("speech_byte", expd.speech_byte, act.speech_byte);
          report_field("irq_pulse", 8'(expd.irq_pulse), 8'(act.irq_pulse));
          report_field("fifo_underrun", 8'(expd.fifo_underrun), 8'(act.fifo_underrun));
          report_field("fifo_overrun", 8'(expd.fifo_overrun), 8'(act.fifo_overrun));
          report_field("pad", 8'h00, 8'(out_tdata[23:20]));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed beats, random scenarios, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin : seq
    int unsigned pick, n, k, cnt;
    logic [7:0]  ld;
    clear_shadow();

    // directed part
    add_beat(CMD_FIFO_POP, 5'd0, 8'h00, 1'b1);        // pop on empty after reset
    add_beat(CMD_TICK, 5'd0, 8'h00, 1'b1);            // tick with timer stopped
    add_beat(CMD_RIOT_RD, ADR_PORT_A, 8'h00, 1'b0);   // speech busy shows in bit 2
    add_beat(CMD_RIOT_WR, ADR_DIR_A, 8'hff, 1'b1);
    add_beat(CMD_RIOT_WR, ADR_PORT_A, 8'hff, 1'b1);
    add_beat(CMD_RIOT_WR, ADR_PORT_B, 8'ha5, 1'b1);
    add_beat(CMD_RIOT_WR, ADR_PORT_A, 8'h00, 1'b1);   // falling bit 0 -> strobe
    add_beat(CMD_RIOT_WR, ADR_DIR_B, 8'h5a, 1'b0);
    add_beat(CMD_RIOT_RD, ADR_DIR_B, 8'h00, 1'b1);
    add_beat(CMD_RIOT_WR, 5'd4, 8'hff, 1'b1);         // unused offset, ignored
    add_beat(CMD_RIOT_RD, 5'd31, 8'h00, 1'b1);        // timer load is write only
    add_beat(CMD_RIOT_WR, ADR_TMR_LOAD, 8'h04, 1'b1); // count 2
    add_beat(CMD_TICK, 5'd0, 8'h00, 1'b1);
    add_beat(CMD_TICK, 5'd0, 8'h00, 1'b1);            // expires
    add_beat(CMD_RIOT_RD, ADR_IRQ_FLG, 8'h00, 1'b1);
    add_beat(CMD_RIOT_RD, ADR_IRQ_FLG, 8'h00, 1'b1);  // cleared by the read
    add_beat(CMD_RIOT_WR, ADR_TMR_LOAD, 8'h01, 1'b1); // zero load
    add_beat(CMD_TICK, 5'd0, 8'h00, 1'b1);            // wraps to 255
    add_beat(CMD_REPLY_WR, 5'd0, 8'h5a, 1'b1);
    add_beat(CMD_READY_RD, 5'd0, 8'h00, 1'b1);
    add_beat(CMD_REPLY_RD, 5'd0, 8'h00, 1'b1);
    for (int i = 0; i < DEPTH; i++) add_beat(CMD_FIFO_PSH, 5'd0, 8'(8'h11 * i), 1'b1);
    add_beat(CMD_READY_RD, 5'd0, 8'h00, 1'b1);        // full flag
    add_beat(CMD_FIFO_PSH, 5'd31, 8'hee, 1'b1);       // push when full: overrun
    add_beat(CMD_FIFO_POP, 5'd0, 8'h00, 1'b1);
    add_beat(CMD_SND_RST, 5'd0, 8'h00, 1'b1);
    add_beat(4'hf, 5'h1f, 8'hff, 1'b1);               // unused command

    // random part: mostly well-formed scenarios with random content
    while (n_real_items < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // fill then drain; sometimes past full, sometimes past empty
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          add_beat(CMD_FIFO_PSH, 5'($urandom_range(0, 31)), rand_byte(), rand_rdy());
          if ($urandom_range(0, 3) == 0)
            add_beat(($urandom_range(0, 1) != 0) ? CMD_READY_RD : CMD_RIOT_RD,
                     ADR_PORT_A, rand_byte(), rand_rdy());
        end
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          add_beat(CMD_FIFO_POP, 5'($urandom_range(0, 31)), rand_byte(), rand_rdy());
      end else if (pick < 42) begin
        // timer load and a run of ticks, mostly short counts
        k = $urandom_range(0, 9);
        ld = (k < 7) ? 8'($urandom_range(0, 15)) :
             (k < 9) ? 8'($urandom_range(16, 63)) : rand_byte();
        add_beat(CMD_RIOT_WR, ADR_TMR_LOAD, ld, rand_rdy());
        cnt = 32'(ld >> 1);
        n = (cnt == 0) ? $urandom_range(1, 4) : cnt + $urandom_range(0, 3);
        if (n > 70) n = 70;
        for (int i = 0; i < n; i++) add_beat(CMD_TICK, rand_addr(), rand_byte(), rand_rdy());
        add_beat(CMD_RIOT_RD, ADR_IRQ_FLG, rand_byte(), rand_rdy());
        if ($urandom_range(0, 2) == 0)
          add_beat(CMD_RIOT_RD, ADR_IRQ_FLG, rand_byte(), rand_rdy());
      end else if (pick < 57) begin
        // port A bit 0 high then low to fire the speech strobe
        k = $urandom_range(0, 3);
        ld = (k < 2) ? 8'hff : (k == 2) ? (rand_byte() | 8'h01) : rand_byte();
        add_beat(CMD_RIOT_WR, ADR_DIR_A, ld, rand_rdy());
        add_beat(CMD_RIOT_WR, ADR_PORT_B, rand_byte(), rand_rdy());
        add_beat(CMD_RIOT_WR, ADR_PORT_A, rand_byte() | 8'h01, rand_rdy());
        add_beat(CMD_RIOT_WR, ADR_PORT_A, rand_byte() & 8'hfe, rand_rdy());
        add_beat(CMD_RIOT_RD, ADR_PORT_A, rand_byte(), rand_rdy());
      end else if (pick < 67) begin
        // mailbox round trip
        add_beat(CMD_REPLY_WR, rand_addr(), rand_byte(), rand_rdy());
        add_beat(CMD_READY_RD, rand_addr(), rand_byte(), rand_rdy());
        add_beat(CMD_RIOT_RD, ADR_PORT_A, rand_byte(), rand_rdy());
        add_beat(CMD_REPLY_RD, rand_addr(), rand_byte(), rand_rdy());
        add_beat(CMD_READY_RD, rand_addr(), rand_byte(), rand_rdy());
      end else if (pick < 71) begin
        add_beat(CMD_SND_RST, rand_addr(), rand_byte(), rand_rdy());
      end else begin
        // noise: any command, any offset, including the unused ones
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          add_beat(4'($urandom_range(0, 15)), rand_addr(), rand_byte(), rand_rdy());
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // drain; the watchdog covers a core that stops answering
    while (bus_access_q.size() != 0 || in_tvalid || pending_responses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && pending_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
